FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfla assertion failed");

// next-cycle implication, disabled during reset
`define SFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfla assertion failed");

`endif

FILE: rtl/sfla_pkg.sv
// types and constants of the slab free list allocator
// no dependencies
`default_nettype none

package sfla_pkg;

    localparam int DATA_W    = 64;
    localparam int SIZE_W    = 13;
    localparam int REGION_W  = 13;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int CARVED_W  = 24;

    localparam logic [CARVED_W-1:0] CARVE_MAX      = 24'hFF_FFFF;
    localparam logic [SIZE_W-1:0]   OBJ_SIZE_RESET = 13'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_ADD   = 2'd2
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic push;
        logic carve_step;
        logic pop;
        logic set_empty;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic free_empty;
        logic carve_more;
    } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sfla_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfla_ctrl.sv
// controller state machine of the slab free list allocator
// depends on sfla_pkg
`default_nettype none

module sfla_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [sfla_pkg::CMD_W-1:0] command,
    output logic                            in_stall,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    input  wire sfla_pkg::ctrl_stat_t       stat,
    output sfla_pkg::ctrl_cmd_t             cmd
);

    import sfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_CARVE,
        S_POP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   alloc_reg;
    logic   alloc_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_emit;

    assign can_emit  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        alloc_next = alloc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    alloc_next = (command == CMD_ALLOC);
                    unique case (command)
                        CMD_ALLOC:
                        begin
                            if (stat.free_empty)
                            begin
                                state_next = S_CARVE;
                            end
                            else
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = S_POP;
                            end
                        end
                        CMD_FREE:
                        begin
                            state_next = S_PUSH;
                        end
                        CMD_ADD:
                        begin
                            state_next = S_CARVE;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                if (can_emit)
                begin
                    cmd.push   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CARVE:
            begin
                if (stat.carve_more)
                begin
                    cmd.carve_step = 1'b1;
                end
                else if (alloc_reg && stat.free_empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (alloc_reg)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_POP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_POP:
            begin
                if (can_emit)
                begin
                    cmd.pop    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (can_emit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfla_datapath.sv
// datapath: object size register, free list store, indices, counters, result word
// depends on sfla_pkg and sfla_ram
`default_nettype none

module sfla_datapath #(
    parameter int PAGE_BYTES  = 4096,
    parameter int STORE_DEPTH = 1024,
    parameter int LINK_BYTES  = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            object_size_write,
    input  wire logic [sfla_pkg::SIZE_W-1:0]     object_size,
    input  wire logic [sfla_pkg::CMD_W-1:0]      command,
    input  wire logic [sfla_pkg::DATA_W-1:0]     address,
    input  wire logic [sfla_pkg::REGION_W-1:0]   region_size,
    input  wire sfla_pkg::ctrl_cmd_t             cmd,
    output sfla_pkg::ctrl_stat_t                 stat,
    output logic      [sfla_pkg::DATA_W-1:0]     object_address,
    output logic      [sfla_pkg::STATUS_W-1:0]   status,
    output logic      [sfla_pkg::COUNT_W-1:0]    free_count,
    output logic      [sfla_pkg::CARVED_W-1:0]   object_count
);

    import sfla_pkg::*;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int FT_W   = $clog2(STORE_DEPTH + 1);
    localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
    localparam int LIM_W  = (PAGE_W > REGION_W) ? PAGE_W : REGION_W;

    logic [SIZE_W-1:0]   object_size_reg;
    logic [DATA_W-1:0]   addr_reg;
    logic [LIM_W-1:0]    limit_reg;
    logic [LIM_W-1:0]    off_reg;
    logic                fail_reg;
    logic                empty_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    tail_reg;
    logic [FT_W-1:0]     free_total_reg;
    logic [CARVED_W-1:0] carved_reg;
    logic [DATA_W-1:0]   object_address_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  free_count_reg;
    logic [CARVED_W-1:0] object_count_reg;

    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_next;
    logic [FT_W-1:0]     free_total_next;
    logic [CARVED_W-1:0] carved_next;
    logic                fail_next;
    logic                empty_next;
    status_t             status_next;

    logic [LIM_W:0]      carve_end;
    logic                carve_more;
    logic                full;
    logic                push_req;
    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic [DATA_W-1:0]   rd_data;

    assign carve_end  = {1'b0, off_reg} + (LIM_W + 1)'(object_size_reg);
    assign carve_more = (carve_end <= {1'b0, limit_reg});
    assign full       = (free_total_reg == FT_W'(STORE_DEPTH));
    assign push_req   = cmd.push || (cmd.carve_step && carve_more);
    assign wr_en      = push_req && !full;
    assign wr_data    = addr_reg + DATA_W'(off_reg);

    assign stat.free_empty = (free_total_reg == '0);
    assign stat.carve_more = carve_more;

    sfla_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        tail_next       = tail_reg;
        head_next       = head_reg;
        free_total_next = free_total_reg;
        carved_next     = carved_reg;
        if (wr_en)
        begin
            tail_next       = (tail_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            free_total_next = free_total_reg + 1'b1;
            if (cmd.carve_step && (carved_reg != CARVE_MAX))
            begin
                carved_next = carved_reg + 1'b1;
            end
        end
        if (cmd.pop)
        begin
            head_next       = (head_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            free_total_next = free_total_reg - 1'b1;
        end
    end

    assign fail_next  = !cmd.load && (fail_reg || (push_req && full));
    assign empty_next = !cmd.load && (empty_reg || cmd.set_empty);

    always_comb
    begin
        if (empty_next)
        begin
            status_next = ST_EMPTY;
        end
        else if (fail_next)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_size_reg <= OBJ_SIZE_RESET;
            head_reg        <= '0;
            tail_reg        <= '0;
            free_total_reg  <= '0;
            carved_reg      <= '0;
        end
        else
        begin
            if (object_size_write && (object_size >= SIZE_W'(LINK_BYTES)))
            begin
                object_size_reg <= object_size;
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_total_reg <= free_total_next;
            carved_reg     <= carved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fail_reg  <= fail_next;
        empty_reg <= empty_next;
        if (cmd.load)
        begin
            addr_reg  <= address;
            off_reg   <= '0;
            limit_reg <= (command == CMD_ALLOC) ? LIM_W'(PAGE_BYTES) : LIM_W'(region_size);
        end
        else if (cmd.carve_step && carve_more)
        begin
            off_reg <= carve_end[LIM_W-1:0];
        end
        if (cmd.emit)
        begin
            object_address_reg <= cmd.pop ? rd_data : '0;
            status_reg         <= status_next;
            free_count_reg     <= COUNT_W'(free_total_next);
            object_count_reg   <= carved_next;
        end
    end

    assign object_address = object_address_reg;
    assign status         = status_reg;
    assign free_count     = free_count_reg;
    assign object_count   = object_count_reg;

endmodule

`default_nettype wire

FILE: rtl/slab_free_list_allocator.sv
// top level of the slab free list allocator
// depends on sfla_pkg, sfla_ctrl, sfla_datapath and assert_macros.svh
`default_nettype none

// One word in, one word out. Free writes the store once; allocate from a
// non-empty list reads the head of the store, whose read port is registered.
// Add-region, and allocate on an empty list, walk the region one object per
// cycle through the single store write port, the region being the page when
// allocating. The walk lies between the accept and the end-of-walk check,
// which is followed by the step that writes the result; for allocate that
// step pops the head unless the list stayed empty. Input is stalled for the
// whole of that work, and longer while a stalled result still holds the
// output register; a finished result sits in the output register while the
// next word is taken.
module slab_free_list_allocator #(
    parameter int PAGE_BYTES  = 4096,
    parameter int STORE_DEPTH = 1024,
    parameter int LINK_BYTES  = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            object_size_write,
    input  wire logic [sfla_pkg::SIZE_W-1:0]     object_size,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sfla_pkg::CMD_W-1:0]      command,
    input  wire logic [sfla_pkg::DATA_W-1:0]     address,
    input  wire logic [sfla_pkg::REGION_W-1:0]   region_size,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [sfla_pkg::DATA_W-1:0]     object_address,
    output logic      [sfla_pkg::STATUS_W-1:0]   status,
    output logic      [sfla_pkg::COUNT_W-1:0]    free_count,
    output logic      [sfla_pkg::CARVED_W-1:0]   object_count
);

    import sfla_pkg::*;

    `include "assert_macros.svh"

    ctrl_cmd_t  ctl_cmd;
    ctrl_stat_t ctl_stat;

    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (ctl_stat),
        .cmd       (ctl_cmd)
    );

    sfla_datapath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .STORE_DEPTH (STORE_DEPTH),
        .LINK_BYTES  (LINK_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .object_size_write (object_size_write),
        .object_size       (object_size),
        .command           (command),
        .address           (address),
        .region_size       (region_size),
        .cmd               (ctl_cmd),
        .stat              (ctl_stat),
        .object_address    (object_address),
        .status            (status),
        .free_count        (free_count),
        .object_count      (object_count)
    );

    // busy right after taking a word
    `SFLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // never pop an empty list
    `SFLA_ASSERT_NOW(a_pop_nonempty, clk, rst_n, ctl_cmd.pop, !ctl_stat.free_empty)
    // never overwrite a pending result
    `SFLA_ASSERT_NOW(a_emit_slot_free, clk, rst_n, ctl_cmd.emit, !out_valid || !out_stall)
    // empty result carries no object
    `SFLA_ASSERT_NOW(a_empty_zero_addr, clk, rst_n, out_valid && (status == ST_EMPTY),
        object_address == '0)

endmodule

`default_nettype wire
